FILE: design/mesh_tangent_accumulator_assert.svh
// Assertion macros used by the tangent accumulator controller.
`ifndef MESH_TANGENT_ACCUMULATOR_ASSERT_SVH
`define MESH_TANGENT_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define MTA_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mta: assertion failed");
// Next-cycle implication, checked on every clock edge outside reset.
`define MTA_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mta: assertion failed");
`else
`define MTA_ASSERT_IMP(name, ante, cons)
`define MTA_ASSERT_NXT(name, ante, cons)
`endif
`endif

FILE: design/mta_pkg.sv
// Types and constants shared by the tangent accumulator modules.
package mta_pkg;

    localparam int SUM_W   = 26;
    localparam int OUT_W   = 16;
    localparam int VIDX_W  = 10;
    localparam int VCNT_W  = 11;
    localparam logic [OUT_W-1:0] ONE_Q14 = 16'd16384;

    localparam logic [1:0] CFG_INDEXED = 2'd0;
    localparam logic [1:0] CFG_VCOUNT  = 2'd1;

    typedef enum logic [1:0] {
        OPC_LOAD = 2'd0,
        OPC_TRI  = 2'd1,
        OPC_READ = 2'd2,
        OPC_NOP  = 2'd3
    } mta_opc_t;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [VIDX_W-1:0]       vertex_index;
        logic signed [15:0]      pos_x;
        logic signed [15:0]      pos_y;
        logic signed [15:0]      pos_z;
        logic signed [15:0]      tex_u;
        logic signed [15:0]      tex_v;
        logic [VIDX_W-1:0]       corner_a;
        logic [VIDX_W-1:0]       corner_b;
        logic [VIDX_W-1:0]       corner_c;
    } mta_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] tangent_x;
        logic signed [OUT_W-1:0] tangent_y;
        logic signed [OUT_W-1:0] tangent_z;
        logic                    zero_tangent;
    } mta_out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_DIFF,
        OP_NLOAD_RAW,
        OP_NLOAD_SUM,
        OP_SHR,
        OP_SHL,
        OP_SQ_INIT,
        OP_SQ_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_TAKE,
        OP_OUT,
        OP_OUT_ZERO
    } mta_op_t;

    typedef enum logic [2:0] {
        TK_NONE,
        TK_DET,
        TK_RAW,
        TK_SSQ_FIRST,
        TK_SSQ
    } mta_take_t;

    typedef enum logic [3:0] {
        MS_DET_A,
        MS_DET_B,
        MS_X_A,
        MS_X_B,
        MS_Y_A,
        MS_Y_B,
        MS_Z_A,
        MS_Z_B,
        MS_SQ_X,
        MS_SQ_Y,
        MS_SQ_Z
    } mta_msel_t;

    typedef enum logic [1:0] {
        AD_A,
        AD_B,
        AD_C,
        AD_VI
    } mta_addr_t;

    typedef enum logic [1:0] {
        SW_ZERO,
        SW_SET,
        SW_ACC
    } mta_sumw_t;

    typedef struct packed {
        logic      capture;
        mta_op_t   op;
        logic [1:0] sub;
        logic      mul_en;
        mta_msel_t mul_sel;
        mta_take_t take;
        mta_addr_t addr;
        logic      rd_en;
        logic      vtx_we;
        logic      sum_we;
        mta_sumw_t sum_mode;
    } mta_cmd_t;

    typedef struct packed {
        mta_opc_t opcode;
        logic     vi_ok;
        logic     corners_ok;
        logic     det_zero;
        logic     m_zero;
        logic     big_hi;
        logic     big_lo;
    } mta_stat_t;

endpackage

FILE: design/mta_ram.sv
// Generic single-port RAM with registered read data.
module mta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata <= mem[addr];
        end
    end

endmodule

FILE: design/mta_ctrl.sv
// Controller state machine sequencing loads, triangles and reads.
`include "mesh_tangent_accumulator_assert.svh"
module mta_ctrl import mta_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  logic      indexed_mode,
    input  mta_stat_t stat,
    output mta_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_LOAD, S_RDA, S_RDB, S_RDC, S_LATC, S_DIFF, S_MUL,
        S_TCHK, S_NLOAD, S_RSUM, S_RSUMW, S_NCHK, S_SSQ, S_SQI, S_SQ, S_DIVI,
        S_DIV, S_DIVT, S_SRD, S_SWR, S_OUT, S_OUTZ
    } state_t;

    localparam logic [4:0] MUL_LAST = 5'd8;
    localparam logic [4:0] SSQ_LAST = 5'd3;
    localparam logic [4:0] SQ_LAST  = 5'd25;
    localparam logic [4:0] DIV_LAST = 5'd15;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] k_reg, k_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free, is_read;

    assign out_free = !m_valid_reg || m_ready;
    assign is_read  = (stat.opcode == OPC_READ);
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (stat.opcode)
                    OPC_LOAD: state_next = S_LOAD;
                    OPC_TRI:  state_next = stat.corners_ok ? S_RDA : S_IDLE;
                    OPC_READ: state_next = stat.vi_ok ? S_RSUM : S_OUTZ;
                    OPC_NOP:  state_next = S_IDLE;
                endcase
            end
            S_LOAD: begin
                cmd.addr = AD_VI;
                if (stat.vi_ok) begin
                    cmd.vtx_we   = 1'b1;
                    cmd.sum_we   = 1'b1;
                    cmd.sum_mode = SW_ZERO;
                end
                state_next = S_IDLE;
            end
            S_RDA: begin
                cmd.rd_en  = 1'b1;
                cmd.addr   = AD_A;
                state_next = S_RDB;
            end
            S_RDB: begin
                cmd.rd_en  = 1'b1;
                cmd.addr   = AD_B;
                cmd.op     = OP_LATCH;
                cmd.sub    = 2'd0;
                state_next = S_RDC;
            end
            S_RDC: begin
                cmd.rd_en  = 1'b1;
                cmd.addr   = AD_C;
                cmd.op     = OP_LATCH;
                cmd.sub    = 2'd1;
                state_next = S_LATC;
            end
            S_LATC: begin
                cmd.op     = OP_LATCH;
                cmd.sub    = 2'd2;
                state_next = S_DIFF;
            end
            S_DIFF: begin
                cmd.op     = OP_DIFF;
                cnt_next   = '0;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.mul_en  = (cnt_reg < MUL_LAST);
                cmd.mul_sel = mta_msel_t'(cnt_reg[3:0]);
                case (cnt_reg)
                    5'd2: cmd.take = TK_DET;
                    5'd4: begin
                        cmd.take = TK_RAW;
                        cmd.sub  = 2'd0;
                    end
                    5'd6: begin
                        cmd.take = TK_RAW;
                        cmd.sub  = 2'd1;
                    end
                    5'd8: begin
                        cmd.take = TK_RAW;
                        cmd.sub  = 2'd2;
                    end
                    default: cmd.take = TK_NONE;
                endcase
                if (cnt_reg == MUL_LAST) begin
                    state_next = S_TCHK;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_TCHK: begin
                state_next = stat.det_zero ? S_IDLE : S_NLOAD;
            end
            S_NLOAD: begin
                cmd.op     = OP_NLOAD_RAW;
                state_next = S_NCHK;
            end
            S_RSUM: begin
                cmd.rd_en  = 1'b1;
                cmd.addr   = AD_VI;
                state_next = S_RSUMW;
            end
            S_RSUMW: begin
                cmd.op     = OP_NLOAD_SUM;
                state_next = S_NCHK;
            end
            S_NCHK: begin
                if (stat.m_zero) begin
                    state_next = is_read ? S_OUTZ : S_IDLE;
                end else if (stat.big_hi) begin
                    cmd.op = OP_SHR;
                end else if (stat.big_lo) begin
                    cmd.op = OP_SHL;
                end else begin
                    cnt_next   = '0;
                    state_next = S_SSQ;
                end
            end
            S_SSQ: begin
                cmd.mul_en  = (cnt_reg < SSQ_LAST);
                cmd.mul_sel = mta_msel_t'(4'(MS_SQ_X) + cnt_reg[3:0]);
                if (cnt_reg == 5'd1) begin
                    cmd.take = TK_SSQ_FIRST;
                end else if (cnt_reg >= 5'd2) begin
                    cmd.take = TK_SSQ;
                end
                if (cnt_reg == SSQ_LAST) begin
                    state_next = S_SQI;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_SQI: begin
                cmd.op     = OP_SQ_INIT;
                cnt_next   = '0;
                state_next = S_SQ;
            end
            S_SQ: begin
                cmd.op = OP_SQ_STEP;
                if (cnt_reg == SQ_LAST) begin
                    k_next     = '0;
                    state_next = S_DIVI;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_DIVI: begin
                cmd.op     = OP_DIV_INIT;
                cmd.sub    = k_reg;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.op = OP_DIV_STEP;
                if (cnt_reg == DIV_LAST) begin
                    state_next = S_DIVT;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_DIVT: begin
                cmd.op  = OP_DIV_TAKE;
                cmd.sub = k_reg;
                if (k_reg == 2'd2) begin
                    k_next = '0;
                    if (is_read) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = indexed_mode ? S_SRD : S_SWR;
                    end
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_DIVI;
                end
            end
            S_SRD: begin
                cmd.rd_en  = 1'b1;
                cmd.addr   = mta_addr_t'(k_reg);
                state_next = S_SWR;
            end
            S_SWR: begin
                cmd.addr     = mta_addr_t'(k_reg);
                cmd.sum_we   = 1'b1;
                cmd.sum_mode = indexed_mode ? SW_ACC : SW_SET;
                if (k_reg == 2'd2) begin
                    k_next     = '0;
                    state_next = S_IDLE;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = indexed_mode ? S_SRD : S_SWR;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.op       = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_OUTZ: begin
                if (out_free) begin
                    cmd.op       = OP_OUT_ZERO;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `MTA_ASSERT_IMP(a_sq_count, state_reg == S_SQ, cnt_reg <= SQ_LAST)
    `MTA_ASSERT_IMP(a_out_read, state_reg == S_OUT || state_reg == S_OUTZ, stat.opcode == OPC_READ)
    `MTA_ASSERT_NXT(a_capture, s_valid && s_ready, state_reg == S_DECODE)

endmodule

FILE: design/mta_dp.sv
// Datapath: vertex stores, shared multiplier, normaliser, square root and divider.
module mta_dp import mta_pkg::*; #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 16
) (
    input  logic              aclk,
    input  mta_cmd_t          cmd,
    input  mta_in_t           s_item,
    input  logic [VCNT_W-1:0] vertex_count,
    output mta_stat_t         stat,
    output mta_out_t          out_item
);

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CB   = COORD_BITS;
    localparam int DW   = CB + 1;
    localparam int MW   = (DW > 25) ? DW : 25;
    localparam int PW   = 2 * MW;
    localparam int RW   = 2 * CB + 3;
    localparam int NW   = ((RW > SUM_W) ? RW : SUM_W) + 1;
    localparam int SQW  = 51;
    localparam int LW   = 26;
    localparam int NUMW = 39;
    localparam int QW   = 16;
    localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W+1)'((1 << (SUM_W - 1)) - 1);
    localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W+1)'(1 << (SUM_W - 1));

    mta_in_t                 item_reg;
    logic signed [CB-1:0]    vp_reg [3][3];
    logic signed [CB-1:0]    vt_reg [3][2];
    logic signed [DW-1:0]    q0_reg [3];
    logic signed [DW-1:0]    q1_reg [3];
    logic signed [DW-1:0]    du0_reg, dv0_reg, du1_reg, dv1_reg;
    logic signed [PW-1:0]    prod_reg, acc_reg;
    logic                    det_neg_reg, det_zero_reg;
    logic signed [RW-1:0]    raw_reg [3];
    logic [NW-1:0]           m_reg [3];
    logic                    neg_reg [3];
    logic [SQW-1:0]          ssq_reg, srem_reg, sres_reg, sbit_reg;
    logic [LW:0]             drem_reg;
    logic [QW-1:0]           dnum_reg, q_reg;
    logic signed [OUT_W-1:0] t_reg [3];
    mta_out_t                out_reg;

    logic [AW-1:0]           ram_addr;
    logic [3*CB-1:0]         pos_rdata, pos_wdata;
    logic [2*CB-1:0]         tex_rdata, tex_wdata;
    logic [3*SUM_W-1:0]      sum_rdata, sum_wdata;
    logic signed [MW-1:0]    mul_a, mul_b;
    logic signed [PW:0]      dsum, rval;
    logic signed [NW:0]      src [3];
    logic [SQW-1:0]          trial;
    logic [LW-1:0]           len;
    logic [NUMW-1:0]         numer;
    logic [LW+1:0]           r2;
    logic [QW-1:0]           qcap;
    logic signed [SUM_W:0]   acc_sum [3];

    function automatic logic idx_ok(input logic [VIDX_W-1:0] idx,
                                    input logic [VCNT_W-1:0] vc);
        return ({1'b0, idx} < vc) && (32'(idx) < MAX_VERTICES);
    endfunction

    function automatic logic signed [MW-1:0] sq_op(input logic [NW-1:0] m);
        return $signed({{(MW-24){1'b0}}, m[23:0]});
    endfunction

    // Store address selection.
    always_comb begin
        case (cmd.addr)
            AD_A:    ram_addr = AW'(item_reg.corner_a);
            AD_B:    ram_addr = AW'(item_reg.corner_b);
            AD_C:    ram_addr = AW'(item_reg.corner_c);
            default: ram_addr = AW'(item_reg.vertex_index);
        endcase
    end

    assign pos_wdata = {CB'($unsigned(item_reg.pos_z)), CB'($unsigned(item_reg.pos_y)),
                        CB'($unsigned(item_reg.pos_x))};
    assign tex_wdata = {CB'($unsigned(item_reg.tex_v)), CB'($unsigned(item_reg.tex_u))};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc_sum[i] = (SUM_W+1)'($signed(sum_rdata[i*SUM_W +: SUM_W]))
                       + (SUM_W+1)'(t_reg[i]);
        end
        case (cmd.sum_mode)
            SW_SET: begin
                sum_wdata = {SUM_W'(t_reg[2]), SUM_W'(t_reg[1]), SUM_W'(t_reg[0])};
            end
            SW_ACC: begin
                for (int i = 0; i < 3; i++) begin
                    if (acc_sum[i] > SUM_MAX) begin
                        sum_wdata[i*SUM_W +: SUM_W] = SUM_MAX[SUM_W-1:0];
                    end else if (acc_sum[i] < SUM_MIN) begin
                        sum_wdata[i*SUM_W +: SUM_W] = SUM_MIN[SUM_W-1:0];
                    end else begin
                        sum_wdata[i*SUM_W +: SUM_W] = acc_sum[i][SUM_W-1:0];
                    end
                end
            end
            default: sum_wdata = '0;
        endcase
    end

    mta_ram #(.WIDTH(3 * CB), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .aclk(aclk), .we(cmd.vtx_we), .re(cmd.rd_en), .addr(ram_addr),
        .wdata(pos_wdata), .rdata(pos_rdata)
    );

    mta_ram #(.WIDTH(2 * CB), .DEPTH(MAX_VERTICES)) u_tex_ram (
        .aclk(aclk), .we(cmd.vtx_we), .re(cmd.rd_en), .addr(ram_addr),
        .wdata(tex_wdata), .rdata(tex_rdata)
    );

    mta_ram #(.WIDTH(3 * SUM_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
        .aclk(aclk), .we(cmd.sum_we), .re(cmd.rd_en), .addr(ram_addr),
        .wdata(sum_wdata), .rdata(sum_rdata)
    );

    // Shared multiplier operands.
    always_comb begin
        case (cmd.mul_sel)
            MS_DET_A: begin mul_a = MW'(du0_reg); mul_b = MW'(dv1_reg);   end
            MS_DET_B: begin mul_a = MW'(dv0_reg); mul_b = MW'(du1_reg);   end
            MS_X_A:   begin mul_a = MW'(dv1_reg); mul_b = MW'(q0_reg[0]); end
            MS_X_B:   begin mul_a = MW'(dv0_reg); mul_b = MW'(q1_reg[0]); end
            MS_Y_A:   begin mul_a = MW'(dv1_reg); mul_b = MW'(q0_reg[1]); end
            MS_Y_B:   begin mul_a = MW'(dv0_reg); mul_b = MW'(q1_reg[1]); end
            MS_Z_A:   begin mul_a = MW'(dv1_reg); mul_b = MW'(q0_reg[2]); end
            MS_Z_B:   begin mul_a = MW'(dv0_reg); mul_b = MW'(q1_reg[2]); end
            MS_SQ_X:  begin mul_a = sq_op(m_reg[0]); mul_b = sq_op(m_reg[0]); end
            MS_SQ_Y:  begin mul_a = sq_op(m_reg[1]); mul_b = sq_op(m_reg[1]); end
            MS_SQ_Z:  begin mul_a = sq_op(m_reg[2]); mul_b = sq_op(m_reg[2]); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign dsum = (PW+1)'(acc_reg) - (PW+1)'(prod_reg);
    assign rval = det_neg_reg ? -dsum : dsum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (cmd.op == OP_NLOAD_SUM) begin
                src[i] = (NW+1)'($signed(sum_rdata[i*SUM_W +: SUM_W]));
            end else begin
                src[i] = (NW+1)'(raw_reg[i]);
            end
        end
    end

    assign trial = sres_reg + sbit_reg;
    assign len   = sres_reg[LW-1:0];
    assign numer = {NUMW'(m_reg[cmd.sub][23:0]) << 14} + NUMW'(len >> 1);
    assign r2    = {drem_reg, dnum_reg[QW-1]};
    assign qcap  = (q_reg > ONE_Q14) ? ONE_Q14 : q_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_item;
        end
        if (cmd.mul_en) begin
            acc_reg  <= prod_reg;
            prod_reg <= mul_a * mul_b;
        end
        case (cmd.take)
            TK_DET: begin
                det_neg_reg  <= (dsum < 0);
                det_zero_reg <= (dsum == 0);
            end
            TK_RAW:       raw_reg[cmd.sub] <= rval[RW-1:0];
            TK_SSQ_FIRST: ssq_reg <= SQW'(prod_reg);
            TK_SSQ:       ssq_reg <= ssq_reg + SQW'(prod_reg);
            default: ;
        endcase
        case (cmd.op)
            OP_LATCH: begin
                vp_reg[cmd.sub][0] <= pos_rdata[CB-1:0];
                vp_reg[cmd.sub][1] <= pos_rdata[2*CB-1:CB];
                vp_reg[cmd.sub][2] <= pos_rdata[3*CB-1:2*CB];
                vt_reg[cmd.sub][0] <= tex_rdata[CB-1:0];
                vt_reg[cmd.sub][1] <= tex_rdata[2*CB-1:CB];
            end
            OP_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    q0_reg[i] <= DW'(vp_reg[1][i]) - DW'(vp_reg[0][i]);
                    q1_reg[i] <= DW'(vp_reg[2][i]) - DW'(vp_reg[0][i]);
                end
                du0_reg <= DW'(vt_reg[1][0]) - DW'(vt_reg[0][0]);
                dv0_reg <= DW'(vt_reg[1][1]) - DW'(vt_reg[0][1]);
                du1_reg <= DW'(vt_reg[2][0]) - DW'(vt_reg[0][0]);
                dv1_reg <= DW'(vt_reg[2][1]) - DW'(vt_reg[0][1]);
            end
            OP_NLOAD_RAW, OP_NLOAD_SUM: begin
                for (int i = 0; i < 3; i++) begin
                    neg_reg[i] <= (src[i] < 0);
                    m_reg[i]   <= (src[i] < 0) ? NW'(-src[i]) : NW'(src[i]);
                end
            end
            OP_SHR: begin
                for (int i = 0; i < 3; i++) begin
                    m_reg[i] <= m_reg[i] >> 1;
                end
            end
            OP_SHL: begin
                for (int i = 0; i < 3; i++) begin
                    m_reg[i] <= m_reg[i] << 1;
                end
            end
            OP_SQ_INIT: begin
                srem_reg <= ssq_reg;
                sres_reg <= '0;
                sbit_reg <= SQW'(1) << (SQW - 1);
            end
            OP_SQ_STEP: begin
                if (srem_reg >= trial) begin
                    srem_reg <= srem_reg - trial;
                    sres_reg <= (sres_reg >> 1) + sbit_reg;
                end else begin
                    sres_reg <= sres_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            OP_DIV_INIT: begin
                drem_reg <= (LW+1)'(numer >> QW);
                dnum_reg <= numer[QW-1:0];
                q_reg    <= '0;
            end
            OP_DIV_STEP: begin
                if (r2 >= (LW+2)'(len)) begin
                    drem_reg <= (LW+1)'(r2 - (LW+2)'(len));
                    q_reg    <= {q_reg[QW-2:0], 1'b1};
                end else begin
                    drem_reg <= r2[LW:0];
                    q_reg    <= {q_reg[QW-2:0], 1'b0};
                end
                dnum_reg <= dnum_reg << 1;
            end
            OP_DIV_TAKE: begin
                t_reg[cmd.sub] <= neg_reg[cmd.sub] ? -$signed(qcap) : $signed(qcap);
            end
            OP_OUT: begin
                out_reg <= '{tangent_x: t_reg[0], tangent_y: t_reg[1],
                             tangent_z: t_reg[2], zero_tangent: 1'b0};
            end
            OP_OUT_ZERO: begin
                out_reg <= '{tangent_x: '0, tangent_y: '0, tangent_z: '0,
                             zero_tangent: 1'b1};
            end
            default: ;
        endcase
    end

    always_comb begin
        stat.opcode     = mta_opc_t'(item_reg.opcode);
        stat.vi_ok      = idx_ok(item_reg.vertex_index, vertex_count);
        stat.corners_ok = idx_ok(item_reg.corner_a, vertex_count)
                       && idx_ok(item_reg.corner_b, vertex_count)
                       && idx_ok(item_reg.corner_c, vertex_count);
        stat.det_zero   = det_zero_reg;
        stat.m_zero     = (m_reg[0] == '0) && (m_reg[1] == '0) && (m_reg[2] == '0);
        stat.big_hi     = (|m_reg[0][NW-1:24]) || (|m_reg[1][NW-1:24])
                       || (|m_reg[2][NW-1:24]);
        stat.big_lo     = !((|m_reg[0][NW-1:23]) || (|m_reg[1][NW-1:23])
                       || (|m_reg[2][NW-1:23]));
    end

    assign out_item = out_reg;

endmodule

FILE: design/mesh_tangent_accumulator.sv
// Top level of the mesh tangent accumulator: configuration registers and block wiring.
//
//   Channel  Direction  Handshake             Carries
//   s_       in         s_valid / s_ready     mta_in_t command transaction
//   m_       out        m_valid / m_ready     mta_out_t tangent transaction
//   cfg_     in         cfg_valid / cfg_ready register index and write data
//
// Each command is taken one at a time. A read waits for the output register to be free,
// and a read of a stored sum runs longer or shorter with the normalising shift. A
// triangle stops early when it is out of range or degenerate; in full it runs three
// vertex fetches, eight products on the shared multiplier, a one-bit-per-cycle
// normalising shift of up to 23 steps, three squares, a 26-step square root, three
// 16-step divisions and three writes of the sum store, each preceded by a read of the
// old sum in indexed mode.
// Reset is synchronous and active low; it clears the controller and both registers.
// The stores hold no reset value; a load clears the stored sum of its vertex. A result waiting in the output
// register does not stop the next command from being taken.
module mesh_tangent_accumulator import mta_pkg::*; #(
    parameter int MAX_VERTICES = 1024,
    parameter int COORD_BITS   = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mta_in_t           s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output mta_out_t          m_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [VCNT_W-1:0] cfg_data
);

    logic              indexed_mode_reg;
    logic [VCNT_W-1:0] vertex_count_reg;
    mta_cmd_t          cmd;
    mta_stat_t         stat;

    // Configuration writes are always taken; unknown indices are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            indexed_mode_reg <= 1'b0;
            vertex_count_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_INDEXED: indexed_mode_reg <= cfg_data[0];
                CFG_VCOUNT:  vertex_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The controller walks each transaction through its steps and owns the output valid.
    mta_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .indexed_mode (indexed_mode_reg),
        .stat         (stat),
        .cmd          (cmd)
    );

    // The datapath holds the stores and all arithmetic, and the output register.
    mta_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .aclk         (aclk),
        .cmd          (cmd),
        .s_item       (s_item),
        .vertex_count (vertex_count_reg),
        .stat         (stat),
        .out_item     (m_item)
    );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the mesh tangent accumulator.
module tb;
    import mta_pkg::*;

    // Watchdog limit in clock cycles, well above the slowest correct run.
    localparam int CYCLE_LIMIT = 4000000;
    // Quiet cycles allowed for the longest command to finish.
    localparam int SETTLE      = 250;
    localparam int NVERT       = 1024;
    localparam longint SUM_HI  = (64'sd1 <<< 25) - 1;
    localparam longint SUM_LO  = -(64'sd1 <<< 25);

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    mta_in_t  s_item;
    logic     m_valid;
    logic     m_ready;
    mta_out_t m_item;
    logic     cfg_valid;
    logic     cfg_ready;
    logic [1:0]        cfg_index;
    logic [VCNT_W-1:0] cfg_data;

    mesh_tangent_accumulator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the block: vertex data, tangent sums and both registers.
    longint pos_x_mem [NVERT];
    longint pos_y_mem [NVERT];
    longint pos_z_mem [NVERT];
    longint tex_u_mem [NVERT];
    longint tex_v_mem [NVERT];
    longint sum_x_mem [NVERT];
    longint sum_y_mem [NVERT];
    longint sum_z_mem [NVERT];
    bit     loaded [NVERT];
    int     loaded_list [$];
    bit     accumulate;
    int     vcount;

    mta_out_t tangent_due [$];
    int       errors;
    int       cycles;
    int       stall_pct;
    int       gap_pct;

    // A row of the directed part: either a register write or a command transaction,
    // optionally carrying a result that is typed in by hand.
    typedef struct {
        bit         is_cfg;
        logic [1:0] reg_idx;
        int         reg_val;
        mta_in_t    cmd;
        bit         fixed;
        mta_out_t   result;
    } stim_row_t;

    stim_row_t stim_rows [$];

    initial begin
        aclk = 1'b0;
    end

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("mesh_tangent_accumulator: mismatch");
            $finish;
        end
    end

    function automatic int vertex_limit();
        return (vcount < NVERT) ? vcount : NVERT;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned s);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Scales a vector to unit length in Q1.14. An all-zero vector gives the zero flag.
    function automatic mta_out_t unit_tangent(longint vx, longint vy, longint vz);
        longint          v [3];
        longint unsigned m [3];
        bit              neg [3];
        longint unsigned big;
        longint unsigned ssq;
        longint unsigned len;
        longint unsigned q;
        longint          t [3];
        mta_out_t        r;
        v[0] = vx;
        v[1] = vy;
        v[2] = vz;
        big  = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            m[i]   = neg[i] ? -v[i] : v[i];
            if (m[i] > big)
                big = m[i];
        end
        r = '0;
        if (big == 0) begin
            r.zero_tangent = 1'b1;
            return r;
        end
        while (big >= (64'd1 << 24)) begin
            for (int i = 0; i < 3; i++)
                m[i] = m[i] >> 1;
            big = big >> 1;
        end
        while (big < (64'd1 << 23)) begin
            for (int i = 0; i < 3; i++)
                m[i] = m[i] << 1;
            big = big << 1;
        end
        ssq = 0;
        for (int i = 0; i < 3; i++)
            ssq = ssq + m[i] * m[i];
        len = int_sqrt(ssq);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * 16384 + len / 2) / len;
            if (q > 16384)
                q = 16384;
            t[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        r.tangent_x = t[0][15:0];
        r.tangent_y = t[1][15:0];
        r.tangent_z = t[2][15:0];
        return r;
    endfunction

    function automatic longint clamp_sum(longint x);
        return (x > SUM_HI) ? SUM_HI : ((x < SUM_LO) ? SUM_LO : x);
    endfunction

    // Applies one accepted command to the shadow state; returns 1 with the tangent
    // when the command produces a result.
    function automatic bit apply_command(mta_in_t c, output mta_out_t r);
        int       lim;
        int       idx [3];
        longint   q0 [3];
        longint   q1 [3];
        longint   raw [3];
        longint   du0, dv0, du1, dv1, det;
        mta_out_t t;
        lim = vertex_limit();
        r   = '0;
        case (mta_opc_t'(c.opcode))
            OPC_LOAD: begin
                if (c.vertex_index < lim) begin
                    pos_x_mem[c.vertex_index] = c.pos_x;
                    pos_y_mem[c.vertex_index] = c.pos_y;
                    pos_z_mem[c.vertex_index] = c.pos_z;
                    tex_u_mem[c.vertex_index] = c.tex_u;
                    tex_v_mem[c.vertex_index] = c.tex_v;
                    sum_x_mem[c.vertex_index] = 0;
                    sum_y_mem[c.vertex_index] = 0;
                    sum_z_mem[c.vertex_index] = 0;
                    if (!loaded[c.vertex_index]) begin
                        loaded[c.vertex_index] = 1'b1;
                        loaded_list.push_back(c.vertex_index);
                    end
                end
                return 1'b0;
            end
            OPC_TRI: begin
                idx[0] = c.corner_a;
                idx[1] = c.corner_b;
                idx[2] = c.corner_c;
                if (idx[0] >= lim || idx[1] >= lim || idx[2] >= lim)
                    return 1'b0;
                q0[0] = pos_x_mem[idx[1]] - pos_x_mem[idx[0]];
                q0[1] = pos_y_mem[idx[1]] - pos_y_mem[idx[0]];
                q0[2] = pos_z_mem[idx[1]] - pos_z_mem[idx[0]];
                q1[0] = pos_x_mem[idx[2]] - pos_x_mem[idx[0]];
                q1[1] = pos_y_mem[idx[2]] - pos_y_mem[idx[0]];
                q1[2] = pos_z_mem[idx[2]] - pos_z_mem[idx[0]];
                du0 = tex_u_mem[idx[1]] - tex_u_mem[idx[0]];
                dv0 = tex_v_mem[idx[1]] - tex_v_mem[idx[0]];
                du1 = tex_u_mem[idx[2]] - tex_u_mem[idx[0]];
                dv1 = tex_v_mem[idx[2]] - tex_v_mem[idx[0]];
                det = du0 * dv1 - dv0 * du1;
                if (det == 0)
                    return 1'b0;
                for (int i = 0; i < 3; i++) begin
                    raw[i] = dv1 * q0[i] - dv0 * q1[i];
                    if (det < 0)
                        raw[i] = -raw[i];
                end
                t = unit_tangent(raw[0], raw[1], raw[2]);
                if (t.zero_tangent)
                    return 1'b0;
                for (int k = 0; k < 3; k++) begin
                    if (accumulate) begin
                        sum_x_mem[idx[k]] = clamp_sum(sum_x_mem[idx[k]] + longint'(t.tangent_x));
                        sum_y_mem[idx[k]] = clamp_sum(sum_y_mem[idx[k]] + longint'(t.tangent_y));
                        sum_z_mem[idx[k]] = clamp_sum(sum_z_mem[idx[k]] + longint'(t.tangent_z));
                    end else begin
                        sum_x_mem[idx[k]] = t.tangent_x;
                        sum_y_mem[idx[k]] = t.tangent_y;
                        sum_z_mem[idx[k]] = t.tangent_z;
                    end
                end
                return 1'b0;
            end
            OPC_READ: begin
                r = '0;
                r.zero_tangent = 1'b1;
                if (c.vertex_index < lim)
                    r = unit_tangent(sum_x_mem[c.vertex_index], sum_y_mem[c.vertex_index],
                                     sum_z_mem[c.vertex_index]);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic mta_in_t make_cmd(mta_opc_t op, int vi, int px, int py, int pz,
                                         int tu, int tv, int a, int b, int c);
        mta_in_t m;
        m.opcode       = op;
        m.vertex_index = vi[VIDX_W-1:0];
        m.pos_x        = px[15:0];
        m.pos_y        = py[15:0];
        m.pos_z        = pz[15:0];
        m.tex_u        = tu[15:0];
        m.tex_v        = tv[15:0];
        m.corner_a     = a[VIDX_W-1:0];
        m.corner_b     = b[VIDX_W-1:0];
        m.corner_c     = c[VIDX_W-1:0];
        return m;
    endfunction

    function automatic mta_out_t make_tangent(int x, int y, int z, bit zf);
        mta_out_t r;
        r.tangent_x    = x[15:0];
        r.tangent_y    = y[15:0];
        r.tangent_z    = z[15:0];
        r.zero_tangent = zf;
        return r;
    endfunction

    function automatic void add_cmd(mta_in_t c);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.cmd    = c;
        row.fixed  = 1'b0;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_checked(mta_in_t c, mta_out_t r);
        stim_row_t row;
        row.is_cfg = 1'b0;
        row.cmd    = c;
        row.fixed  = 1'b1;
        row.result = r;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_cfg(logic [1:0] idx, int val);
        stim_row_t row;
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        stim_rows.push_back(row);
    endfunction

    // Presents one command transaction and waits for it to be taken. The shadow state
    // is updated in acceptance order; a fixed result, if given, replaces the prediction.
    task automatic send_cmd(mta_in_t c, bit fixed, mta_out_t fixed_result);
        mta_out_t r;
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= c;
        do @(posedge aclk); while (!s_ready);
        if (apply_command(c, r))
            tangent_due.push_back(fixed ? fixed_result : r);
    endtask

    // Waits for every outstanding tangent, then for the longest command to drain.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tangent_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Register writes only happen while the block is idle.
    task automatic write_reg(logic [1:0] idx, int val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[VCNT_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_INDEXED)
            accumulate = val[0];
        else if (idx == CFG_VCOUNT)
            vcount = val & 32'h7ff;
    endtask

    // Picks a loaded vertex below the current limit, or -1 when none is found.
    function automatic int pick_loaded();
        int v;
        if (loaded_list.size() == 0)
            return -1;
        for (int n = 0; n < 40; n++) begin
            v = loaded_list[$urandom_range(loaded_list.size() - 1)];
            if (v < vertex_limit())
                return v;
        end
        return -1;
    endfunction

    // Random coordinate: mostly full range, sometimes small to keep triangles sensible.
    function automatic int rand_coord();
        int v;
        v = $urandom;
        if ($urandom_range(3) == 0)
            v = $signed(v[15:0]) >>> $urandom_range(8, 2);
        return v;
    endfunction

    function automatic mta_in_t random_cmd();
        mta_in_t c;
        int      sel;
        int      a, b, d;
        int      lim;
        c = '0;
        c.vertex_index = VIDX_W'($urandom);
        c.corner_a     = VIDX_W'($urandom);
        c.corner_b     = VIDX_W'($urandom);
        c.corner_c     = VIDX_W'($urandom);
        c.pos_x = 16'(rand_coord());
        c.pos_y = 16'(rand_coord());
        c.pos_z = 16'(rand_coord());
        c.tex_u = 16'(rand_coord());
        c.tex_v = 16'(rand_coord());
        lim = vertex_limit();
        sel = $urandom_range(99);
        a   = pick_loaded();
        b   = pick_loaded();
        d   = pick_loaded();
        if (sel < 5) begin
            c.opcode = OPC_NOP;
        end else if (sel < 35 || a < 0) begin
            c.opcode = OPC_LOAD;
            if (lim > 0 && $urandom_range(9) != 0)
                c.vertex_index = VIDX_W'($urandom_range(lim - 1));
        end else if (sel < 70) begin
            c.opcode   = OPC_TRI;
            c.corner_a = VIDX_W'(a);
            c.corner_b = VIDX_W'(b);
            c.corner_c = VIDX_W'(d);
            // Broken triangles: a repeated corner, or one corner beyond the limit.
            if ($urandom_range(9) == 0)
                c.corner_b = VIDX_W'(a);
            else if ($urandom_range(9) == 0 && lim < NVERT)
                c.corner_c = VIDX_W'($urandom_range(NVERT - 1, lim));
        end else begin
            c.opcode       = OPC_READ;
            c.vertex_index = VIDX_W'(a);
            if ($urandom_range(4) == 0 && lim < NVERT)
                c.vertex_index = VIDX_W'($urandom_range(NVERT - 1, lim));
        end
        return c;
    endfunction

    // Result checker and receiver stall generator.
    always @(posedge aclk) begin
        mta_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tangent_due.size() == 0) begin
                $error("unexpected tangent transaction %h", m_item);
                errors = errors + 1;
            end else begin
                want = tangent_due.pop_front();
                if (m_item.tangent_x !== want.tangent_x) begin
                    $error("tangent_x expected %0d actual %0d", want.tangent_x, m_item.tangent_x);
                    errors = errors + 1;
                end
                if (m_item.tangent_y !== want.tangent_y) begin
                    $error("tangent_y expected %0d actual %0d", want.tangent_y, m_item.tangent_y);
                    errors = errors + 1;
                end
                if (m_item.tangent_z !== want.tangent_z) begin
                    $error("tangent_z expected %0d actual %0d", want.tangent_z, m_item.tangent_z);
                    errors = errors + 1;
                end
                if (m_item.zero_tangent !== want.zero_tangent) begin
                    $error("zero_tangent expected %0b actual %0b", want.zero_tangent,
                           m_item.zero_tangent);
                    errors = errors + 1;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        int       phase_gap [4];
        int       phase_stall [4];
        int       vc_choice [8];
        mta_out_t none;
        mta_in_t  c;
        phase_gap   = '{0, 75, 0, 35};
        phase_stall = '{0, 0, 75, 35};
        vc_choice   = '{1024, 3, 0, 1024, 17, 1024, 600, 1023};
        none        = '0;
        errors      = 0;
        cycles      = 0;
        stall_pct   = 0;
        gap_pct     = 0;
        accumulate  = 1'b0;
        vcount      = 0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_item      = '0;
        m_ready     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_INDEXED;
        cfg_data    = '0;
        foreach (loaded[i])
            loaded[i] = 1'b0;

        // After reset no vertex is in use, so a read is out of range.
        add_checked(make_cmd(OPC_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), make_tangent(0, 0, 0, 1));
        add_cfg(CFG_VCOUNT, 4);
        add_cfg(CFG_INDEXED, 0);
        add_cmd(make_cmd(OPC_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_cmd(make_cmd(OPC_LOAD, 1, 4096, 0, 0, 4096, 0, 0, 0, 0));
        add_cmd(make_cmd(OPC_LOAD, 2, 0, 4096, 0, 0, 4096, 0, 0, 0));
        // A freshly loaded vertex has a cleared sum.
        add_checked(make_cmd(OPC_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0), make_tangent(0, 0, 0, 1));
        // Axis-aligned unit triangle: the tangent is exactly +x.
        add_cmd(make_cmd(OPC_TRI, 0, 0, 0, 0, 0, 0, 0, 1, 2));
        add_checked(make_cmd(OPC_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                    make_tangent(16384, 0, 0, 0));
        add_cmd(make_cmd(OPC_LOAD, 3, 32767, -32768, 32767, -32768, 32767, 0, 0, 0));
        add_cmd(make_cmd(OPC_TRI, 0, 0, 0, 0, 0, 0, 3, 1, 2));
        // Repeated corner gives a zero determinant; a corner past the limit is ignored.
        add_cmd(make_cmd(OPC_TRI, 0, 0, 0, 0, 0, 0, 0, 0, 1));
        add_cmd(make_cmd(OPC_TRI, 0, 0, 0, 0, 0, 0, 0, 1, 1023));
        // A load past the limit is dropped.
        add_cmd(make_cmd(OPC_LOAD, 1023, -1, -1, -1, -1, -1, 0, 0, 0));
        add_checked(make_cmd(OPC_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0),
                    make_tangent(0, 0, 0, 1));
        add_cmd(make_cmd(OPC_NOP, 1023, -1, -1, -1, -1, -1, 1023, 1023, 1023));
        add_cmd(make_cmd(OPC_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0));
        add_cmd(make_cmd(OPC_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0));
        add_cfg(CFG_INDEXED, 1);
        add_cmd(make_cmd(OPC_TRI, 0, 0, 0, 0, 0, 0, 0, 1, 3));
        add_cmd(make_cmd(OPC_TRI, 0, 0, 0, 0, 0, 0, 0, 1, 2));
        add_cmd(make_cmd(OPC_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_cmd(make_cmd(OPC_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].is_cfg)
                write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_val);
            else
                send_cmd(stim_rows[i].cmd, stim_rows[i].fixed, stim_rows[i].result);
        end

        // Accumulation: a run of identical +x contributions grows the corner sums,
        // then a read of the first corner.
        repeat (60)
            send_cmd(make_cmd(OPC_TRI, 0, 0, 0, 0, 0, 0, 0, 1, 2), 1'b0, none);
        send_cmd(make_cmd(OPC_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none);

        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_VCOUNT, vc_choice[p]);
            write_reg(CFG_INDEXED, (p % 3 == 0) ? 0 : 1);
            gap_pct   = phase_gap[p % 4];
            stall_pct = phase_stall[p % 4];
            for (int n = 0; n < 58; n++) begin
                // Half-way through, hold back until every tangent has come out.
                if (n == 29) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (tangent_due.size() != 0)
                        @(posedge aclk);
                end
                c = random_cmd();
                send_cmd(c, 1'b0, none);
            end
        end

        drain();
        if (errors == 0)
            $display("mesh_tangent_accumulator: match");
        else
            $display("mesh_tangent_accumulator: mismatch");
        $finish;
    end

endmodule

FILE: mesh_tangent_accumulator.f
+incdir+design
design/mta_pkg.sv
design/mta_ram.sv
design/mta_ctrl.sv
design/mta_dp.sv
design/mesh_tangent_accumulator.sv
tb/tb.sv
